### rtl/core/mspt_pkg.sv
// ---------------------------------------------------------------------------
// mspt_pkg
// Shared types, constants and helpers for the multi-stage pattern trigger.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mspt_pkg;

    localparam int STAGES     = 4;   // trigger stages, 1..4
    localparam int SAMPLE_W   = 16;
    localparam int PACKED_W   = 64;  // four 16-bit lanes
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 32;
    localparam int Q_DEPTH    = 8;   // rescan queue depth
    localparam int Q_AW       = 3;
    localparam int MAX_RES    = 8;   // results kept per request
    localparam int STAGE_W    = 2;   // stage index 0..3

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_MASKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_VALUES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd3;

    // request types
    localparam logic REQ_ARM    = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic                done;
    } res_item_t;

    // one 16-bit lane of a packed mask/value register
    function automatic logic [SAMPLE_W-1:0] lane(input logic [PACKED_W-1:0] packed_word,
                                                 input logic [STAGE_W-1:0]  idx);
        logic [SAMPLE_W-1:0] r;
        r = packed_word[idx*SAMPLE_W +: SAMPLE_W];
        return r;
    endfunction

endpackage

### rtl/core/mspt_ifs.sv
// ---------------------------------------------------------------------------
// mspt channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mspt_req_if
    import mspt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SAMPLE_W-1:0] sample_in;

    modport source (output valid, req_type, sample_in, input ready);
    modport sink   (input valid, req_type, sample_in, output ready);
endinterface

interface mspt_res_if
    import mspt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [SAMPLE_W-1:0] sample_out;
    logic                last;
    logic                done_res;

    modport source (output valid, item_kind, sample_out, last, done_res, input ready);
    modport sink   (input valid, item_kind, sample_out, last, done_res, output ready);
endinterface

interface mspt_cfg_if
    import mspt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PACKED_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/multi_stage_pattern_trigger.sv
// ---------------------------------------------------------------------------
// multi_stage_pattern_trigger
// Logic-analyzer trigger: up to four mask/value stages, marker on trigger,
// replay of the matched samples, then pass-through up to a sample limit.
// ---------------------------------------------------------------------------
// Channel | Dir | Payload                                 | Handshake
// req     | in  | req_type, sample_in                     | valid/ready
// res     | out | item_kind, sample_out, last, done_res   | valid/ready
// cfg     | in  | index (2b), data (64b)                  | valid/ready, ready tied high
//
// Order: one request at a time. A request is accepted, then runs its
// comparator steps one by one (a queued sample compared or passed, a
// stored match replayed or requeued), finds the queue empty or the block
// stopped (after leaving any replay), and releases the final result. An
// arm or a sample while stopped goes straight to the release; a rescan
// after a partial match requeues the stored matches but the first and
// repeats compares. All steps share the single comparator, and results
// pass through a one-entry staging register.
// Reset: all control state clears; the queue and the match store do not.
// Stalls: while a result is held and the output register is full and not
// taken, every compare, pass and replay step waits; requeue steps do not.
// The last result is held back until the step ends so that it can carry last.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_stage_pattern_trigger
    import mspt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mspt_req_if.sink   req,
    mspt_res_if.source res,
    mspt_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,     // ready for a request
        ST_PROC,     // compare or pass the queue head
        ST_REPLAY,   // pass stored matches after the trigger
        ST_REQUEUE,  // push stored matches back ahead of the queue
        ST_FINISH    // release the held result with last set
    } state_t;

    // configuration
    logic [PACKED_W-1:0] masks_reg;
    logic [PACKED_W-1:0] values_reg;
    logic                wide_reg;
    logic [COUNT_W-1:0]  limit_reg;

    // sequencer state
    state_t              state_reg,      state_next;
    logic [Q_AW-1:0]     head_reg,       head_next;
    logic [Q_AW:0]       cnt_reg,        cnt_next;
    logic [STAGE_W-1:0]  stage_reg,      stage_next;
    logic                fired_reg,      fired_next;
    logic                stopped_reg,    stopped_next;
    logic [COUNT_W-1:0]  count_reg,      count_next;
    logic [3:0]          rcnt_reg,       rcnt_next;    // results this request, 0..8
    logic [STAGE_W:0]    rep_idx_reg,    rep_idx_next;
    logic [STAGE_W:0]    rep_num_reg,    rep_num_next;
    logic [STAGE_W-1:0]  req_idx_reg,    req_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    res_item_t           pend_reg,       pend_next;
    logic                out_valid_reg,  out_valid_next;
    res_item_t           out_item_reg,   out_item_next;
    logic                out_last_reg,   out_last_next;

    // storage
    logic [SAMPLE_W-1:0] q_mem [Q_DEPTH];
    logic [SAMPLE_W-1:0] match_mem [4];

    logic                q_we;
    logic [Q_AW-1:0]     q_waddr;
    logic [SAMPLE_W-1:0] q_wdata;
    logic                m_we;
    logic [STAGE_W-1:0]  m_waddr;
    logic [STAGE_W-1:0]  m_raddr;

    // datapath
    logic [SAMPLE_W-1:0] in_sample;
    logic [SAMPLE_W-1:0] head_sample;
    logic [SAMPLE_W-1:0] stored_sample;
    logic                hit;
    logic [STAGE_W:0]    st_inc;
    logic                fire;
    logic                can_emit;
    logic [COUNT_W-1:0]  cnt_sat;
    logic                limit_hit;
    logic [Q_AW+1:0]     room_sum;
    logic                put_en;
    logic                pass_en;
    res_item_t           put_item;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign res.valid      = out_valid_reg;
    assign res.item_kind  = out_item_reg.kind;
    assign res.sample_out = out_item_reg.sample;
    assign res.done_res   = out_item_reg.done;
    assign res.last       = out_last_reg;

    // narrow mode drops the high byte before anything else sees it
    assign in_sample = wide_reg ? req.sample_in : {8'h00, req.sample_in[7:0]};

    assign head_sample   = q_mem[head_reg];
    assign m_raddr       = (state_reg == ST_REPLAY) ? rep_idx_reg[STAGE_W-1:0] : req_idx_reg;
    assign stored_sample = match_mem[m_raddr];

    // the shared comparator
    assign hit    = (head_sample & lane(masks_reg, stage_reg)) == lane(values_reg, stage_reg);
    assign st_inc = {1'b0, stage_reg} + 1'b1;
    assign fire   = (st_inc >= (STAGE_W+1)'(STAGES))
                 || (lane(masks_reg, st_inc[STAGE_W-1:0]) == '0);

    // room for the requeue: cnt + (stage - 1) <= depth
    assign room_sum = {1'b0, cnt_reg} + {{(Q_AW-STAGE_W+2){1'b0}}, stage_reg};

    // counter step for a passed data item, saturating
    assign cnt_sat   = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign limit_hit = (limit_reg != '0) && (cnt_sat >= limit_reg);

    // a result can be staged when the held one can move to the output register
    assign can_emit = !pend_valid_reg || !out_valid_reg || res.ready;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        stage_next      = stage_reg;
        fired_next      = fired_reg;
        stopped_next    = stopped_reg;
        count_next      = count_reg;
        rcnt_next       = rcnt_reg;
        rep_idx_next    = rep_idx_reg;
        rep_num_next    = rep_num_reg;
        req_idx_next    = req_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        out_last_next   = out_last_reg;

        q_we     = 1'b0;
        q_waddr  = head_reg;
        q_wdata  = in_sample;
        m_we     = 1'b0;
        m_waddr  = stage_reg;
        put_en   = 1'b0;
        pass_en  = 1'b0;
        put_item = '{kind: KIND_DATA, sample: head_sample, done: 1'b0};

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    rcnt_next = '0;
                    if (req.req_type == REQ_ARM)
                    begin
                        stage_next   = '0;
                        fired_next   = 1'b0;
                        count_next   = '0;
                        stopped_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else if (stopped_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        q_we       = 1'b1;
                        cnt_next   = (Q_AW+1)'(1);
                        state_next = ST_PROC;
                    end
                end
            end

            ST_PROC:
            begin
                if (cnt_reg == '0 || stopped_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (can_emit)
                begin
                    if (fired_reg)
                    begin
                        head_next = head_reg + 1'b1;
                        cnt_next  = cnt_reg - 1'b1;
                        put_en    = 1'b1;
                        pass_en   = 1'b1;
                    end
                    else if (hit)
                    begin
                        head_next = head_reg + 1'b1;
                        cnt_next  = cnt_reg - 1'b1;
                        m_we      = 1'b1;
                        if (fire)
                        begin
                            put_en       = 1'b1;
                            put_item     = '{kind: KIND_MARKER, sample: '0, done: 1'b0};
                            fired_next   = 1'b1;
                            stage_next   = '0;
                            rep_idx_next = '0;
                            rep_num_next = st_inc;
                            state_next   = ST_REPLAY;
                        end
                        else
                        begin
                            stage_next = st_inc[STAGE_W-1:0];
                        end
                    end
                    else if (stage_reg != '0)
                    begin
                        // rescan: the sample stays at the head, stored[1..st-1]
                        // go in front of it
                        stage_next = '0;
                        if (room_sum <= (Q_AW+2)'(Q_DEPTH + 1))
                        begin
                            req_idx_next = stage_reg - 1'b1;
                            if (stage_reg != STAGE_W'(1))
                            begin
                                state_next = ST_REQUEUE;
                            end
                        end
                        else
                        begin
                            head_next = head_reg + 1'b1;
                            cnt_next  = cnt_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                end
            end

            ST_REPLAY:
            begin
                if (stopped_reg || rep_idx_reg == rep_num_reg)
                begin
                    state_next = ST_PROC;
                end
                else if (can_emit)
                begin
                    put_en       = 1'b1;
                    pass_en      = 1'b1;
                    put_item     = '{kind: KIND_DATA, sample: stored_sample, done: 1'b0};
                    rep_idx_next = rep_idx_reg + 1'b1;
                end
            end

            ST_REQUEUE:
            begin
                q_we         = 1'b1;
                q_waddr      = head_reg - 1'b1;
                q_wdata      = stored_sample;
                head_next    = head_reg - 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                req_idx_next = req_idx_reg - 1'b1;
                if (req_idx_reg == STAGE_W'(1))
                begin
                    state_next = ST_PROC;
                end
            end

            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // results beyond the per-request limit are dropped
        if (put_en && rcnt_reg < 4'(MAX_RES))
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_item_next  = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = put_item;
            rcnt_next       = rcnt_reg + 1'b1;
        end

        if (pass_en)
        begin
            count_next = cnt_sat;
            if (limit_hit)
            begin
                stopped_next   = 1'b1;
                pend_next.done = 1'b1;   // the newest result, kept or not
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            cnt_reg        <= '0;
            stage_reg      <= '0;
            fired_reg      <= 1'b0;
            stopped_reg    <= 1'b0;
            count_reg      <= '0;
            rcnt_reg       <= '0;
            rep_idx_reg    <= '0;
            rep_num_reg    <= '0;
            req_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            stage_reg      <= stage_next;
            fired_reg      <= fired_next;
            stopped_reg    <= stopped_next;
            count_reg      <= count_next;
            rcnt_reg       <= rcnt_next;
            rep_idx_reg    <= rep_idx_next;
            rep_num_reg    <= rep_num_next;
            req_idx_reg    <= req_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (m_we)
        begin
            match_mem[m_waddr] <= head_sample;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg  <= '0;
            values_reg <= '0;
            wide_reg   <= 1'b0;
            limit_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STAGE_MASKS:  masks_reg  <= cfg.data;
                REG_STAGE_VALUES: values_reg <= cfg.data;
                REG_WIDE_SAMPLES: wide_reg   <= cfg.data[0];
                REG_SAMPLE_LIMIT: limit_reg  <= cfg.data[COUNT_W-1:0];
                default:          limit_reg  <= limit_reg;
            endcase
        end
    end

endmodule

### rtl/core/mspt_checker.sv
// ---------------------------------------------------------------------------
// mspt_checker
// Port-level checks for the pattern trigger, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mspt_checker
    import mspt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic                res_kind,
    input logic [SAMPLE_W-1:0] res_sample,
    input logic                res_last,
    input logic                res_done
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_sample)
                                    && $stable(res_kind) && $stable(res_last))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // a marker carries no sample
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_MARKER) |-> res_sample == '0)
        else $error("marker with sample data");

    // the replayed matches always follow the marker
    a_marker_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_MARKER) |-> !res_last && !res_done)
        else $error("marker closes a request");

    // done only on data
    a_done_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done |-> res_kind == KIND_DATA)
        else $error("done on a marker");

endmodule

bind multi_stage_pattern_trigger mspt_checker u_mspt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_kind   (res.item_kind),
    .res_sample (res.sample_out),
    .res_last   (res.last),
    .res_done   (res.done_res)
);
